/* rtl/core/fbo_pkg.sv */
`default_nettype none

package fbo_pkg;

  localparam int unsigned MAX_FOGS_DEF   = 16;
  localparam int unsigned COORD_BITS_DEF = 20;

  localparam int unsigned ENTRY_IDX_W = 4;
  localparam int unsigned FOG_IDX_W   = 5;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned MARGIN_W    = 13;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FOG_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDEN_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FOG  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [FOG_IDX_W-1:0] DEFAULT_FOG_RST = 5'h1F;

  // one unit in 1/8 steps: smallest overlap credited per axis
  localparam int unsigned OV_FLOOR = 8;

  typedef struct packed {
    logic start;
    logic valid;
    logic glb;
  } eval_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic [FOG_IDX_W-1:0] answer;
  } eval_sts_t;

endpackage

`default_nettype wire

/* rtl/core/fbo_if.sv */
`default_nettype none

interface fbo_in_if #(
  parameter int unsigned COORD_BITS = fbo_pkg::COORD_BITS_DEF
);
  import fbo_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [ENTRY_IDX_W-1:0]        entry_index;
  logic                          entry_global;
  logic signed [COORD_BITS-1:0]  min_x;
  logic signed [COORD_BITS-1:0]  min_y;
  logic signed [COORD_BITS-1:0]  min_z;
  logic signed [COORD_BITS-1:0]  max_x;
  logic signed [COORD_BITS-1:0]  max_y;
  logic signed [COORD_BITS-1:0]  max_z;

  modport source (output valid, opcode, entry_index, entry_global,
                  min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, opcode, entry_index, entry_global,
                  min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fbo_out_if;
  import fbo_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [FOG_IDX_W-1:0] fog_index;

  modport source (output valid, fog_index, input ready);
  modport sink   (input valid, fog_index, output ready);
endinterface

`default_nettype wire

/* rtl/core/fog_box_best_overlap_select.sv */
`default_nettype none

// Fog volume selector. Write requests (opcode 0) store one table slot.
// A query request (opcode 1) rotates the ring of MAX_FOGS table cells
// once past a shared evaluation pipeline, one entry per cycle; a query
// lasts for the ring revolution and the drain of the five-stage
// overlap/volume pipeline. Only the first fog_count entries contribute.
// A new request is taken once the answer has been loaded into the output
// register, even while that answer still waits on the output. Table slots
// read before being written return undefined results. Configuration
// writes belong in idle periods.
module fog_box_best_overlap_select #(
  parameter int unsigned MAX_FOGS   = fbo_pkg::MAX_FOGS_DEF,
  parameter int unsigned COORD_BITS = fbo_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fbo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fbo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fbo_in_if.sink                           in_i,
  fbo_out_if.source                        out_o
);
  import fbo_pkg::*;

  localparam int unsigned IW = (MAX_FOGS > 1) ? $clog2(MAX_FOGS) : 1;
  localparam int unsigned SW = (IW > ENTRY_IDX_W) ? IW : ENTRY_IDX_W;
  localparam int unsigned NW = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int unsigned BW = 3 * COORD_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;

  logic [COUNT_W-1:0]   fog_count_q;
  logic [MARGIN_W-1:0]  margin_q;
  logic [FOG_IDX_W-1:0] default_q;

  logic [BW-1:0] qlo_q, qhi_q;
  logic          out_valid_q;
  logic [FOG_IDX_W-1:0] out_idx_q;

  logic in_fire, wr_fire, q_fire, out_load, out_take;

  eval_ctl_t eval_ctl;
  eval_sts_t eval_sts;

  logic [BW-1:0] in_lo, in_hi;
  logic [BW-1:0] cell_lo [MAX_FOGS];
  logic [BW-1:0] cell_hi [MAX_FOGS];
  logic          cell_glb [MAX_FOGS];
  logic          shift;

  assign in_lo = {in_i.min_z, in_i.min_y, in_i.min_x};
  assign in_hi = {in_i.max_z, in_i.max_y, in_i.max_x};

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign wr_fire    = in_fire && (in_i.opcode == OP_WRITE);
  assign q_fire     = in_fire && (in_i.opcode == OP_QUERY);
  assign shift      = (state_q == ST_RUN);

  for (genvar j = 0; j < MAX_FOGS; j++) begin : g_ring
    logic wr_sel;
    assign wr_sel = wr_fire && (SW'(in_i.entry_index) == SW'(j));
    fbo_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .nb_lo_i  (cell_lo[(j + 1) % MAX_FOGS]),
      .nb_hi_i  (cell_hi[(j + 1) % MAX_FOGS]),
      .nb_glb_i (cell_glb[(j + 1) % MAX_FOGS]),
      .wr_i     (wr_sel),
      .wr_lo_i  (in_lo),
      .wr_hi_i  (in_hi),
      .wr_glb_i (in_i.entry_global),
      .lo_o     (cell_lo[j]),
      .hi_o     (cell_hi[j]),
      .glb_o    (cell_glb[j])
    );
  end

  assign eval_ctl.start = q_fire;
  assign eval_ctl.valid = shift && (NW'(cnt_q) < NW'(fog_count_q));
  assign eval_ctl.glb   = cell_glb[0];

  fbo_eval #(
    .MAX_FOGS   (MAX_FOGS),
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (eval_ctl),
    .idx_i     (cnt_q),
    .lo_i      (cell_lo[0]),
    .hi_i      (cell_hi[0]),
    .qlo_i     (qlo_q),
    .qhi_i     (qhi_q),
    .margin_i  (margin_q),
    .default_i (default_q),
    .sts_o     (eval_sts)
  );

  assign out_take = out_valid_q && out_o.ready;
  assign out_load = (state_q == ST_DRAIN) && !eval_sts.busy && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (q_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == IW'(MAX_FOGS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      fog_count_q <= '0;
      margin_q    <= '0;
      default_q   <= DEFAULT_FOG_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FOG_COUNT:    fog_count_q <= cfg_data_i[COUNT_W-1:0];
          REG_WIDEN_MARGIN: margin_q    <= cfg_data_i[MARGIN_W-1:0];
          REG_DEFAULT_FOG:  default_q   <= cfg_data_i[FOG_IDX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_fire) begin
      qlo_q <= in_lo;
      qhi_q <= in_hi;
    end
    if (out_load) begin
      out_idx_q <= eval_sts.answer;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.fog_index = out_idx_q;

  ap_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == IW'(MAX_FOGS - 1)) |=> state_q == ST_DRAIN)
    else $error("ring revolution length wrong");

  ap_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DRAIN)
    else $error("result raised outside drain");

  ap_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !eval_sts.busy)
    else $error("evaluation busy while idle");

endmodule

`default_nettype wire

/* rtl/core/fbo_cell.sv */
`default_nettype none

// One table slot of the rotating ring.
module fbo_cell #(
  parameter int unsigned COORD_BITS = fbo_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    shift_i,
  input  wire logic [3*COORD_BITS-1:0] nb_lo_i,
  input  wire logic [3*COORD_BITS-1:0] nb_hi_i,
  input  wire logic                    nb_glb_i,
  input  wire logic                    wr_i,
  input  wire logic [3*COORD_BITS-1:0] wr_lo_i,
  input  wire logic [3*COORD_BITS-1:0] wr_hi_i,
  input  wire logic                    wr_glb_i,
  output logic      [3*COORD_BITS-1:0] lo_o,
  output logic      [3*COORD_BITS-1:0] hi_o,
  output logic                         glb_o
);
  import fbo_pkg::*;

  logic [3*COORD_BITS-1:0] lo_q, hi_q;
  logic                    glb_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      lo_q  <= nb_lo_i;
      hi_q  <= nb_hi_i;
      glb_q <= nb_glb_i;
    end else if (wr_i) begin
      lo_q  <= wr_lo_i;
      hi_q  <= wr_hi_i;
      glb_q <= wr_glb_i;
    end
  end

  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
  assign glb_o = glb_q;

endmodule

`default_nettype wire

/* rtl/core/fbo_eval.sv */
`default_nettype none

// Evaluates the entry at the ring head: overlap test, volume, running best.
module fbo_eval #(
  parameter int unsigned MAX_FOGS   = fbo_pkg::MAX_FOGS_DEF,
  parameter int unsigned COORD_BITS = fbo_pkg::COORD_BITS_DEF,
  localparam int unsigned IW = (MAX_FOGS > 1) ? $clog2(MAX_FOGS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fbo_pkg::eval_ctl_t         ctl_i,
  input  wire logic [IW-1:0]              idx_i,
  input  wire logic [3*COORD_BITS-1:0]    lo_i,
  input  wire logic [3*COORD_BITS-1:0]    hi_i,
  input  wire logic [3*COORD_BITS-1:0]    qlo_i,
  input  wire logic [3*COORD_BITS-1:0]    qhi_i,
  input  wire logic [fbo_pkg::MARGIN_W-1:0]  margin_i,
  input  wire logic [fbo_pkg::FOG_IDX_W-1:0] default_i,
  output fbo_pkg::eval_sts_t              sts_o
);
  import fbo_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned EW = ((C > MARGIN_W) ? C : MARGIN_W) + 2;
  localparam int unsigned OW = C;
  localparam int unsigned VW = 3 * OW;

  // stage 1: per-axis overlap
  logic signed [EW-1:0] flo [3];
  logic signed [EW-1:0] fhi [3];
  logic signed [EW-1:0] ql  [3];
  logic signed [EW-1:0] qh  [3];
  logic signed [EW-1:0] hmin [3];
  logic signed [EW-1:0] lmax [3];
  logic signed [EW:0]   dd  [3];
  logic [OW-1:0]        ov_d [3];
  logic                 hit_d;
  logic signed [EW-1:0] mg;

  always_comb begin
    mg    = $signed({{(EW-MARGIN_W){1'b0}}, margin_i});
    hit_d = 1'b1;
    for (int a = 0; a < 3; a++) begin
      ql[a]  = $signed({{(EW-C){qlo_i[a*C+C-1]}}, qlo_i[a*C +: C]});
      qh[a]  = $signed({{(EW-C){qhi_i[a*C+C-1]}}, qhi_i[a*C +: C]});
      flo[a] = $signed({{(EW-C){lo_i[a*C+C-1]}}, lo_i[a*C +: C]}) - mg;
      fhi[a] = $signed({{(EW-C){hi_i[a*C+C-1]}}, hi_i[a*C +: C]}) + mg;
      if (ql[a] > fhi[a] || qh[a] < flo[a]) begin
        hit_d = 1'b0;
      end
      hmin[a] = (ql[a] > flo[a]) ? ql[a] : flo[a];
      lmax[a] = (qh[a] < fhi[a]) ? qh[a] : fhi[a];
      dd[a]   = {lmax[a][EW-1], lmax[a]} - {hmin[a][EW-1], hmin[a]};
      if (dd[a] < $signed((EW+1)'(OV_FLOOR))) begin
        ov_d[a] = OW'(OV_FLOOR);
      end else begin
        ov_d[a] = dd[a][OW-1:0];
      end
    end
  end

  logic          s1_valid_q, s1_glb_q, s1_hit_q;
  logic [IW-1:0] s1_idx_q;
  logic [OW-1:0] s1_ov_q [3];

  logic          s2_valid_q, s2_glb_q;
  logic [IW-1:0] s2_idx_q;
  logic [2*OW-1:0] s2_p_q;
  logic [OW-1:0] s2_ov_q;

  logic          s3_valid_q, s3_glb_q;
  logic [IW-1:0] s3_idx_q;
  logic [2*OW-1:0] s3_lo_q, s3_hi_q;

  logic          s4_valid_q, s4_glb_q;
  logic [IW-1:0] s4_idx_q;
  logic [VW-1:0] s4_vol_q;

  logic [VW-1:0]        best_q, best_d;
  logic [FOG_IDX_W-1:0] ans_q, ans_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      best_q     <= '0;
      ans_q      <= DEFAULT_FOG_RST;
    end else begin
      s1_valid_q <= ctl_i.valid;
      s2_valid_q <= s1_valid_q && (s1_glb_q || s1_hit_q);
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      best_q     <= best_d;
      ans_q      <= ans_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_glb_q <= ctl_i.glb;
    s1_hit_q <= hit_d;
    s1_idx_q <= idx_i;
    for (int a = 0; a < 3; a++) begin
      s1_ov_q[a] <= ov_d[a];
    end
    s2_glb_q <= s1_glb_q;
    s2_idx_q <= s1_idx_q;
    s2_p_q   <= s1_ov_q[0] * s1_ov_q[1];
    s2_ov_q  <= s1_ov_q[2];
    s3_glb_q <= s2_glb_q;
    s3_idx_q <= s2_idx_q;
    s3_lo_q  <= s2_p_q[OW-1:0] * s2_ov_q;
    s3_hi_q  <= s2_p_q[2*OW-1:OW] * s2_ov_q;
    s4_glb_q <= s3_glb_q;
    s4_idx_q <= s3_idx_q;
    s4_vol_q <= {s3_hi_q, {OW{1'b0}}} + {{OW{1'b0}}, s3_lo_q};
  end

  always_comb begin
    best_d = best_q;
    ans_d  = ans_q;
    if (ctl_i.start) begin
      best_d = '0;
      ans_d  = default_i;
    end else if (s4_valid_q) begin
      if (s4_glb_q) begin
        ans_d = FOG_IDX_W'(s4_idx_q);
      end else if (s4_vol_q > best_q) begin
        best_d = s4_vol_q;
        ans_d  = FOG_IDX_W'(s4_idx_q);
      end
    end
  end

  assign sts_o.busy   = s1_valid_q | s2_valid_q | s3_valid_q | s4_valid_q;
  assign sts_o.answer = ans_q;

  ap_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(s1_valid_q))
    else $error("stage 2 valid without stage 1");

  ap_best_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.start |=> best_q >= $past(best_q))
    else $error("best volume decreased within a query");

  ap_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !(s1_valid_q | s2_valid_q | s3_valid_q | s4_valid_q))
    else $error("query started while pipeline busy");

endmodule

`default_nettype wire
